// File: sv/ccrc_pkg.sv
package ccrc_pkg;

    localparam int CRC_MAX_W  = 32;
    localparam int ORDER_W    = 6;
    localparam int TOP_IDX_W  = $clog2(CRC_MAX_W);
    localparam int BITS_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CRC_MAX_W-1:0] POLY_RESET  = 32'h0086_4CFB;
    localparam logic [ORDER_W-1:0]   ORDER_RESET = 6'd24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b1;

    typedef struct packed {
        logic [CRC_MAX_W-1:0] mask;
        logic [CRC_MAX_W-1:0] poly;
        logic [TOP_IDX_W-1:0] top_idx;
    } crc_cfg_t;

endpackage

// File: sv/ccrc_cfg.sv
module ccrc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccrc_pkg::CRC_MAX_W-1:0]      cfg_wdata,
    output ccrc_pkg::crc_cfg_t                  cfg
);

    logic [ccrc_pkg::CRC_MAX_W-1:0] poly_reg;
    logic [ccrc_pkg::ORDER_W-1:0]   order_reg;
    logic [ccrc_pkg::ORDER_W-1:0]   order_eff;
    logic [ccrc_pkg::CRC_MAX_W-1:0] mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= ccrc_pkg::POLY_RESET;
            order_reg <= ccrc_pkg::ORDER_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ccrc_pkg::CFG_POLY:  poly_reg  <= cfg_wdata;
                ccrc_pkg::CFG_ORDER: order_reg <= cfg_wdata[ccrc_pkg::ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    // order zero acts as order one, large orders saturate
    always_comb begin
        if (order_reg == '0) begin
            order_eff = ccrc_pkg::ORDER_W'(1);
        end else if (order_reg > ccrc_pkg::ORDER_W'(ccrc_pkg::CRC_MAX_W)) begin
            order_eff = ccrc_pkg::ORDER_W'(ccrc_pkg::CRC_MAX_W);
        end else begin
            order_eff = order_reg;
        end
    end

    assign mask = {ccrc_pkg::CRC_MAX_W{1'b1}}
                  >> (ccrc_pkg::ORDER_W'(ccrc_pkg::CRC_MAX_W) - order_eff);

    assign cfg.mask    = mask;
    assign cfg.poly    = poly_reg & mask;
    assign cfg.top_idx = ccrc_pkg::TOP_IDX_W'(order_eff - ccrc_pkg::ORDER_W'(1));

endmodule

// File: sv/ccrc_step.sv
module ccrc_step (
    input  ccrc_pkg::crc_cfg_t                  cfg,
    input  logic [ccrc_pkg::CRC_MAX_W-1:0]      crc_in,
    input  logic [ccrc_pkg::BYTE_W-1:0]         data_byte,
    input  logic [ccrc_pkg::BITS_W-1:0]         bit_count,
    output logic [ccrc_pkg::CRC_MAX_W-1:0]      crc_out
);

    logic [ccrc_pkg::BITS_W-1:0]    count_sat;
    logic [ccrc_pkg::CRC_MAX_W-1:0] crc_v;
    logic                           fb;

    always_comb begin
        count_sat = (bit_count > ccrc_pkg::BITS_W'(ccrc_pkg::BYTE_W))
                    ? ccrc_pkg::BITS_W'(ccrc_pkg::BYTE_W) : bit_count;
        crc_v = crc_in & cfg.mask;
        fb    = 1'b0;
        // one conditional xor per message bit, first bit in the top position
        for (int k = 0; k < ccrc_pkg::BYTE_W; k++) begin
            if (ccrc_pkg::BITS_W'(k) < count_sat) begin
                fb    = crc_v[cfg.top_idx] ^ data_byte[ccrc_pkg::BYTE_W-1-k];
                crc_v = (crc_v << 1) & cfg.mask;
                if (fb) begin
                    crc_v = crc_v ^ cfg.poly;
                end
            end
        end
        crc_out = crc_v;
    end

endmodule

// File: sv/configurable_crc_engine.sv
// Configurable CRC engine, MSB first, zero initial value, no final xor.
// Input channel s_*: each item carries up to eight message bits aligned to
// bit 7 of a byte plus a valid-bit count; s_tlast marks the last item of a
// message. Output channel m_*: one item per message holding the checksum,
// masked to the configured order.
// Configuration: cfg_we/cfg_index/cfg_wdata write the polynomial (index 0)
// and the order (index 1); write only while the engine is idle.
// Path: a last item is held in the input register, and its checksum is then
// written to the output register that drives m_tvalid/m_tdata.
// Throughput: one item per cycle while no last item stalls; the byte update is eight
// unrolled xor steps between the input register and the running CRC register.
// Reset: the CRC register clears to zero, polynomial returns to 0x864CFB and
// order to 24, both channels empty.
// Stall: while the output item waits, items without tlast keep flowing;
// a last item holds in the input register and s_tready drops until the
// output item is taken.
module configurable_crc_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // data_byte[7:0], bit_count[11:8]
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccrc_pkg::CRC_MAX_W-1:0]      m_tdata,   // checksum[31:0]
    input  logic                                cfg_we,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccrc_pkg::CRC_MAX_W-1:0]      cfg_wdata
);

    ccrc_pkg::crc_cfg_t             cfg;
    logic                           in_valid_reg;
    logic [ccrc_pkg::BYTE_W-1:0]    in_data_reg;
    logic [ccrc_pkg::BITS_W-1:0]    in_count_reg;
    logic                           in_last_reg;
    logic [ccrc_pkg::CRC_MAX_W-1:0] crc_reg;
    logic [ccrc_pkg::CRC_MAX_W-1:0] crc_next;
    logic                           out_valid_reg;
    logic [ccrc_pkg::CRC_MAX_W-1:0] out_data_reg;
    logic                           out_free;
    logic                           advance;
    logic                           s_accept;

    ccrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccrc_step u_step (
        .cfg       (cfg),
        .crc_in    (crc_reg),
        .data_byte (in_data_reg),
        .bit_count (in_count_reg),
        .crc_out   (crc_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    // only a last item needs room in the output register
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg  <= s_tdata[ccrc_pkg::BYTE_W-1:0];
            in_count_reg <= s_tdata[ccrc_pkg::BYTE_W +: ccrc_pkg::BITS_W];
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (advance) begin
            crc_reg <= in_last_reg ? '0 : crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg <= crc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/ccrc_checker.sv
module ccrc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ccrc_pkg::CRC_MAX_W-1:0]      m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // a waiting output item stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // no checksum can appear while no input item is accepted, checked on s_acc and its past value
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !s_acc && $past(!s_acc) |=> !m_tvalid)
        else $error("output item without a recent input item");

endmodule

bind configurable_crc_engine ccrc_checker u_ccrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/configurable_crc_engine_test.sv
`timescale 1ns / 1ps

module configurable_crc_engine_test;

    localparam int LIMIT_CYCLES = 400000;

    class crc_scoreboard;
        bit [ccrc_pkg::CRC_MAX_W-1:0] poly;
        bit [ccrc_pkg::ORDER_W-1:0]   order;
        bit [ccrc_pkg::CRC_MAX_W-1:0] remainder;
        bit [ccrc_pkg::CRC_MAX_W-1:0] pending_checksums[$];
        int unsigned                  mismatches;
        int unsigned                  checked;
        int unsigned                  items;

        function new();
            poly      = ccrc_pkg::POLY_RESET;
            order     = ccrc_pkg::ORDER_RESET;
            remainder = '0;
        endfunction

        function void set_register(bit [ccrc_pkg::CFG_IDX_W-1:0] idx,
                                   bit [ccrc_pkg::CRC_MAX_W-1:0] value);
            if (idx == ccrc_pkg::CFG_POLY) begin
                poly = value;
            end else if (idx == ccrc_pkg::CFG_ORDER) begin
                order = value[ccrc_pkg::ORDER_W-1:0];
            end
        endfunction

        // advance the running remainder by one accepted item
        function void note_item(bit [ccrc_pkg::BYTE_W-1:0] data,
                                bit [ccrc_pkg::BITS_W-1:0] count, bit last);
            int unsigned                  w;
            int unsigned                  n;
            bit [ccrc_pkg::CRC_MAX_W-1:0] mask;
            bit [ccrc_pkg::CRC_MAX_W-1:0] taps;
            bit [ccrc_pkg::CRC_MAX_W-1:0] crc;
            bit                           fb;
            items++;
            w = (order == 0) ? 1 : ((order > ccrc_pkg::CRC_MAX_W) ? ccrc_pkg::CRC_MAX_W : order);
            mask = {ccrc_pkg::CRC_MAX_W{1'b1}} >> (ccrc_pkg::CRC_MAX_W - w);
            taps = poly & mask;
            crc  = remainder & mask;
            n    = (count > 8) ? 8 : count;
            for (int k = 0; k < n; k++) begin
                fb  = crc[w-1] ^ data[7-k];
                crc = (crc << 1) & mask;
                if (fb) begin
                    crc ^= taps;
                end
            end
            remainder = crc;
            if (last) begin
                pending_checksums.push_back(crc);
                remainder = '0;
            end
        endfunction

        function void check_checksum(logic [ccrc_pkg::CRC_MAX_W-1:0] actual);
            bit [ccrc_pkg::CRC_MAX_W-1:0] want;
            if (pending_checksums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected checksum item: actual %h", actual);
                end
                return;
            end
            want = pending_checksums.pop_front();
            checked++;
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("checksum %0d wrong: expected %h actual %h", checked, want, actual);
                end
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;    // data_byte[7:0], bit_count[11:8]
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [ccrc_pkg::CRC_MAX_W-1:0] m_tdata;           // checksum[31:0]
    logic                           cfg_we    = 1'b0;
    logic [ccrc_pkg::CFG_IDX_W-1:0] cfg_index = ccrc_pkg::CFG_POLY;
    logic [ccrc_pkg::CRC_MAX_W-1:0] cfg_wdata = '0;

    crc_scoreboard sb = new();
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    int unsigned n_settings = 0;
    int unsigned cycle_count = 0;

    configurable_crc_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: check taken items, stall in bursts or for a long hold
    initial begin
        int burst;
        burst = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_checksum(m_tdata);
            end
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (burst > 0) begin
                m_tready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                burst = int'($urandom_range(1, 17)) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(bit [ccrc_pkg::BYTE_W-1:0] data,
                             bit [ccrc_pkg::BITS_W-1:0] count, bit last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, count, data};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(data, count, last);
    endtask

    // wait for every checksum, then let a trailing non-last item settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_checksums.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(bit [ccrc_pkg::CRC_MAX_W-1:0] poly,
                                bit [ccrc_pkg::ORDER_W-1:0] order);
        cfg_we    <= 1'b1;
        cfg_index <= ccrc_pkg::CFG_POLY;
        cfg_wdata <= poly;
        @(posedge aclk);
        sb.set_register(ccrc_pkg::CFG_POLY, poly);
        cfg_index <= ccrc_pkg::CFG_ORDER;
        cfg_wdata <= ccrc_pkg::CRC_MAX_W'(order);
        @(posedge aclk);
        sb.set_register(ccrc_pkg::CFG_ORDER, ccrc_pkg::CRC_MAX_W'(order));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_message();
        int                        len;
        bit [ccrc_pkg::BITS_W-1:0] count;
        bit                        last;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if ($urandom_range(0, 9) == 0) begin
                // empty or oversized bit count
                count = $urandom_range(0, 1) ? 4'd0
                        : ccrc_pkg::BITS_W'($urandom_range(9, 15));
            end else if (last || $urandom_range(0, 5) == 0) begin
                count = ccrc_pkg::BITS_W'($urandom_range(1, 8));
            end else begin
                count = 4'd8;
            end
            send_item(ccrc_pkg::BYTE_W'($urandom_range(0, 255)), count, last);
        end
    endtask

    initial begin
        int unsigned target;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: crc24a
        send_item(8'h00, 4'd8, 1'b0);
        send_item(8'hFF, 4'd8, 1'b1);
        send_item(8'hA5, 4'd3, 1'b0);
        send_item(8'h5A, 4'd0, 1'b0);
        send_item(8'h3C, 4'd15, 1'b1);
        send_item(8'h80, 4'd1, 1'b1);
        send_item(8'h00, 4'd0, 1'b1);
        // order zero acts as order one, polynomial bits above it ignored
        drain();
        write_config(32'hFFFF_FFFF, 6'd0);
        send_item(8'hFF, 4'd8, 1'b0);
        send_item(8'h01, 4'd8, 1'b1);
        send_item(8'h6B, 4'd7, 1'b1);
        // order above the maximum saturates
        drain();
        write_config(32'h04C1_1DB7, 6'd63);
        send_item(8'h31, 4'd8, 1'b0);
        send_item(8'h32, 4'd8, 1'b0);
        send_item(8'h33, 4'd8, 1'b1);
        send_item(8'hFE, 4'd9, 1'b1);
        // order changes between items of one message
        drain();
        write_config(32'h0000_1021, 6'd16);
        send_item(8'hC3, 4'd8, 1'b0);
        send_item(8'h7E, 4'd4, 1'b0);
        drain();
        write_config(32'h0000_0007, 6'd8);
        send_item(8'h9B, 4'd5, 1'b1);
        drain();
        write_config(32'h0000_0000, 6'd32);
        send_item(8'hFF, 4'd8, 1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: write_config($urandom, 6'd1);
                1: write_config($urandom, 6'd32);
                2: write_config(32'h0086_4CFB, 6'd24);
                3: write_config(32'h0080_0063, 6'd24);
                4: write_config(32'h0000_1021, 6'd16);
                5: write_config(32'h0000_009B, 6'd8);
                6: write_config($urandom, ccrc_pkg::ORDER_W'($urandom_range(0, 63)));
                default: write_config($urandom, ccrc_pkg::ORDER_W'($urandom_range(2, 31)));
            endcase
            idle_on = (ph != 3) && (ph != 7);
            // receiver holds off long enough for a last item to back up the input
            if (ph == 2) begin
                hold_cycles = 400;
            end
            target = sb.items + 200;
            while (sb.items < target) begin
                send_message();
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending_checksums.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("sent %0d items under %0d polynomial/order settings, checked %0d checksums",
                 sb.items, n_settings, sb.checked);
        $display("%0d mismatches found, %0d checksums never arrived",
                 sb.mismatches, sb.pending_checksums.size());
        if (sb.mismatches == 0 && sb.pending_checksums.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
sv/ccrc_pkg.sv
sv/ccrc_cfg.sv
sv/ccrc_step.sv
sv/configurable_crc_engine.sv
sv/ccrc_checker.sv
sim/configurable_crc_engine_test.sv
